>>> rtl/flkc_pkg.sv
// shared types and constants of the lookaside key cache
`timescale 1ns / 1ps

package flkc_pkg;

	localparam int LIMIT_W = 5;
	localparam int REQ_W   = 3;

	localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FILL   = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD
	} flkc_state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic upd;
	} flkc_cmd_t;

endpackage

>>> rtl/flkc_ctrl.sv
// sequencer of the lookaside key cache: capture, compare, update
`timescale 1ns / 1ps

module flkc_ctrl import flkc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output flkc_cmd_t cmd
);

	flkc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.cmp  = 1'b0;
		cmd.upd  = 1'b0;
		busy     = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/flkc_dp.sv
// datapath of the lookaside key cache: entry store, key match, ring pointers, result
`timescale 1ns / 1ps

module flkc_dp import flkc_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  flkc_cmd_t             cmd,
	input  logic                  cfg_we,
	input  logic [LIMIT_W-1:0]    cfg_data,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  base_found,
	input  logic                  base_ok,
	output logic                  done,
	output logic                  hit,
	output logic                  found,
	output logic [VALUE_BITS-1:0] value_out,
	output logic                  evicted
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int AW    = PTR_W + 1;

	// entry store, payload only: validity follows from the ring pointers
	logic [KEY_BITS-1:0]   key_mem_q [DEPTH];
	logic [VALUE_BITS-1:0] val_mem_q [DEPTH];
	logic                  fnd_mem_q [DEPTH];

	logic [PTR_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [LIMIT_W-1:0]    limit_q;

	logic [REQ_W-1:0]      req_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  bfound_q;
	logic                  bok_q;

	logic                  hit_s1;
	logic [PTR_W-1:0]      idx_s1;

	logic                  done_q;
	logic                  hit_out_q;
	logic                  found_out_q;
	logic [VALUE_BITS-1:0] value_out_q;
	logic                  evicted_out_q;

	// parallel match over the ring
	logic                  match_any;
	logic [PTR_W-1:0]      match_idx;

	always_comb begin
		logic [AW-1:0] off;
		match_any = 1'b0;
		match_idx = '0;
		for (int i = 0; i < DEPTH; i++) begin
			off = AW'(i) - AW'(ptr_q) + ((PTR_W'(i) < ptr_q) ? AW'(DEPTH) : AW'(0));
			if ((off < AW'(cnt_q)) && (key_mem_q[i] == key_q)) begin
				match_any = 1'b1;
				match_idx = PTR_W'(i);
			end
		end
	end

	// allocation arithmetic
	logic [AW-1:0]    lim;
	logic             need_evict;
	logic [AW-1:0]    slot_sum;
	logic [PTR_W-1:0] slot;
	logic [AW-1:0]    ptr_sum;
	logic [PTR_W-1:0] ptr_alloc;
	logic [CNT_W-1:0] cnt_alloc;

	always_comb begin
		if ((limit_q == '0) || (32'(limit_q) > 32'(DEPTH))) begin
			lim = AW'(DEPTH);
		end else begin
			lim = AW'(limit_q);
		end
		need_evict = AW'(cnt_q) >= lim;
		// new entry always lands just past the current newest one
		slot_sum = AW'(ptr_q) + AW'(cnt_q);
		slot     = (slot_sum >= AW'(DEPTH)) ? PTR_W'(slot_sum - AW'(DEPTH)) : PTR_W'(slot_sum);
		// drop enough oldest entries to leave lim - 1 before the new one
		ptr_sum  = AW'(ptr_q) + AW'(cnt_q) - lim + AW'(1);
		if (!need_evict) begin
			ptr_alloc = ptr_q;
			cnt_alloc = cnt_q + CNT_W'(1);
		end else begin
			ptr_alloc = (ptr_sum >= AW'(DEPTH)) ? PTR_W'(ptr_sum - AW'(DEPTH))
			                                    : PTR_W'(ptr_sum);
			cnt_alloc = CNT_W'(lim);
		end
	end

	logic                  is_write;
	logic                  wr_found;
	logic [VALUE_BITS-1:0] wr_val;

	always_comb begin
		is_write = (req_q == REQ_FILL)
		        || (((req_q == REQ_INSERT) || (req_q == REQ_REMOVE)) && bok_q);
		wr_found = (req_q == REQ_FILL) ? bfound_q : (req_q == REQ_INSERT);
		wr_val   = (req_q == REQ_REMOVE) ? '0 : val_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			cnt_q   <= '0;
			limit_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.upd;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.upd) begin
				if (req_q == REQ_FLUSH) begin
					ptr_q <= '0;
					cnt_q <= '0;
				end else if (is_write && !hit_s1) begin
					ptr_q <= ptr_alloc;
					cnt_q <= cnt_alloc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req_type;
			key_q    <= key;
			val_q    <= value;
			bfound_q <= base_found;
			bok_q    <= base_ok;
		end
		if (cmd.cmp) begin
			hit_s1 <= match_any;
			idx_s1 <= match_idx;
		end
		if (cmd.upd) begin
			hit_out_q     <= 1'b0;
			found_out_q   <= 1'b0;
			value_out_q   <= '0;
			evicted_out_q <= 1'b0;
			if (req_q <= REQ_REMOVE) begin
				hit_out_q <= hit_s1;
			end
			if ((req_q == REQ_LOOKUP) && hit_s1) begin
				found_out_q <= fnd_mem_q[idx_s1];
				value_out_q <= val_mem_q[idx_s1];
			end
			if ((req_q <= REQ_REMOVE) && is_write) begin
				if (hit_s1) begin
					fnd_mem_q[idx_s1] <= wr_found;
					val_mem_q[idx_s1] <= wr_val;
				end else begin
					key_mem_q[slot] <= key_q;
					fnd_mem_q[slot] <= wr_found;
					val_mem_q[slot] <= wr_val;
					evicted_out_q   <= need_evict;
				end
			end
		end
	end

	assign done      = done_q;
	assign hit       = hit_out_q;
	assign found     = found_out_q;
	assign value_out = value_out_q;
	assign evicted   = evicted_out_q;

endmodule

>>> rtl/fifo_lookaside_key_cache.sv
// top level of the fully associative lookaside key cache with fifo replacement
`timescale 1ns / 1ps

// A request is taken when start is high while busy is low; it is then captured, its key is
// compared across all DEPTH entries at once, and the entry store and ring pointers are
// updated, in that order. The result appears on
// hit/found/value_out/evicted for exactly one cycle with done high, the first cycle in
// which busy is low again, and must be taken then: there is no backpressure. A new start
// may be issued in that same cycle. cache_limit is written through cfg_valid/cfg_ready,
// which is ready only while the block is idle; reset clears all entries and there is no
// clearing pass.
module fifo_lookaside_key_cache import flkc_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  base_found,
	input  logic                  base_ok,
	output logic                  done,
	output logic                  hit,
	output logic                  found,
	output logic [VALUE_BITS-1:0] value_out,
	output logic                  evicted,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LIMIT_W-1:0]    cfg_data
);

	flkc_cmd_t cmd;

	flkc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	assign cfg_ready = !busy;

	flkc_dp #(
		.DEPTH      (DEPTH),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.key        (key),
		.value      (value),
		.base_found (base_found),
		.base_ok    (base_ok),
		.done       (done),
		.hit        (hit),
		.found      (found),
		.value_out  (value_out),
		.evicted    (evicted)
	);

	// a result only follows a transaction that was in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a transaction in flight");

	// the sequencer is back in idle when the result shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// eviction only happens when a missing key is allocated
	a_evict_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted) |-> !hit)
		else $error("eviction reported on a hit");

	// an accepted transaction always occupies the block in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !cfg_ready))
		else $error("accepted transaction did not raise busy");

endmodule

>>> tb/flkc_checker.sv
// scoreboard for the lookaside key cache: predicts every request and checks its result
`timescale 1ns / 1ps

module flkc_checker import flkc_pkg::*; #(
	parameter int DEPTH      = 16,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  base_found,
	input  logic                  base_ok,
	input  logic                  done,
	input  logic                  hit,
	input  logic                  found,
	input  logic [VALUE_BITS-1:0] value_out,
	input  logic                  evicted,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [LIMIT_W-1:0]    cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    hit_count,
	output int                    evict_count
);

	typedef struct packed {
		logic                  hit;
		logic                  found;
		logic [VALUE_BITS-1:0] value;
		logic                  evicted;
	} lookup_result_t;

	logic                  ent_valid [DEPTH];
	logic [KEY_BITS-1:0]   ent_key   [DEPTH];
	logic [VALUE_BITS-1:0] ent_value [DEPTH];
	logic                  ent_found [DEPTH];
	int                    oldest;
	int                    occupancy;
	logic [LIMIT_W-1:0]    limit_q;
	lookup_result_t        expected_q [$];

	task automatic clear_entries();
		for (int i = 0; i < DEPTH; i++) begin
			ent_valid[i] = 1'b0;
			ent_key[i]   = '0;
			ent_value[i] = '0;
			ent_found[i] = 1'b0;
		end
		oldest    = 0;
		occupancy = 0;
	endtask

	// new entry goes behind the youngest; oldest ones drop out while at the limit
	task automatic allocate_entry(input logic [KEY_BITS-1:0] k, input logic [VALUE_BITS-1:0] v,
			input logic f, output logic ev);
		int lim;
		int slot;
		lim = (limit_q == 0 || limit_q > DEPTH) ? DEPTH : int'(limit_q);
		ev  = 1'b0;
		while (occupancy >= lim && occupancy > 0) begin
			ent_valid[oldest] = 1'b0;
			oldest = (oldest + 1) % DEPTH;
			occupancy--;
			ev = 1'b1;
		end
		slot = (oldest + occupancy) % DEPTH;
		ent_valid[slot] = 1'b1;
		ent_key[slot]   = k;
		ent_value[slot] = v;
		ent_found[slot] = f;
		occupancy++;
	endtask

	task automatic predict_request(input logic [REQ_W-1:0] req, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v, input logic bf, input logic bok,
			output lookup_result_t r);
		logic matched;
		int   idx;
		logic ev;
		r       = '0;
		matched = 1'b0;
		idx     = 0;
		ev      = 1'b0;
		if (req == REQ_FLUSH) begin
			clear_entries();
			return;
		end
		if (req > REQ_FLUSH)
			return;
		for (int i = 0; i < DEPTH; i++) begin
			if (ent_valid[i] && ent_key[i] == k) begin
				matched = 1'b1;
				idx     = i;
			end
		end
		case (req)
			REQ_LOOKUP: begin
				if (matched) begin
					r.found = ent_found[idx];
					r.value = ent_value[idx];
				end
			end
			REQ_FILL: begin
				if (matched) begin
					ent_found[idx] = bf;
					ent_value[idx] = v;
				end else
					allocate_entry(k, v, bf, ev);
			end
			REQ_INSERT: begin
				if (bok && matched) begin
					ent_found[idx] = 1'b1;
					ent_value[idx] = v;
				end else if (bok)
					allocate_entry(k, v, 1'b1, ev);
			end
			REQ_REMOVE: begin
				// a successful remove leaves a negative entry behind
				if (bok && matched) begin
					ent_found[idx] = 1'b0;
					ent_value[idx] = '0;
				end else if (bok)
					allocate_entry(k, '0, 1'b0, ev);
			end
			default: ;
		endcase
		r.hit     = matched;
		r.evicted = ev;
	endtask

	always @(posedge clk or negedge arst_n) begin : sample
		lookup_result_t want;
		lookup_result_t got;
		if (!arst_n) begin
			clear_entries();
			limit_q = '0;
			expected_q.delete();
			fail_count  = 0;
			pending     = 0;
			hit_count   = 0;
			evict_count = 0;
		end else begin
			// a result always belongs to an earlier transaction, so check before taking a new one
			if (done) begin
				got = {hit, found, value_out, evicted};
				if (expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with nothing outstanding: %s",
						$time, "expected none,");
					$display("%0t:   actual hit=%0b found=%0b value_out=%h evicted=%0b",
						$time, got.hit, got.found, got.value, got.evicted);
				end else begin
					want = expected_q.pop_front();
					if (got.hit !== want.hit || got.found !== want.found ||
							got.value !== want.value || got.evicted !== want.evicted) begin
						fail_count++;
						$display("%0t: expected hit=%0b found=%0b value_out=%h evicted=%0b,",
							$time, want.hit, want.found, want.value, want.evicted);
						$display("%0t:   actual hit=%0b found=%0b value_out=%h evicted=%0b",
							$time, got.hit, got.found, got.value, got.evicted);
					end
					hit_count   += got.hit;
					evict_count += got.evicted;
				end
			end
			if (cfg_valid && cfg_ready)
				limit_q = cfg_data;
			if (start && !busy) begin
				predict_request(req_type, key, value, base_found, base_ok, want);
				expected_q.push_back(want);
			end
			pending = expected_q.size();
		end
	end

endmodule

>>> tb/tb_fifo_lookaside_key_cache.sv
// testbench top for the lookaside key cache: stimulus, limit settings and verdict
`timescale 1ns / 1ps

module tb_fifo_lookaside_key_cache import flkc_pkg::*; ();

	localparam int DEPTH           = 16;
	localparam int KEY_BITS        = 32;
	localparam int VALUE_BITS      = 32;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 88;
	localparam int POOL_MAX        = 24;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic [REQ_W-1:0]      req_type   = '0;
	logic [KEY_BITS-1:0]   key        = '0;
	logic [VALUE_BITS-1:0] value      = '0;
	logic                  base_found = 1'b0;
	logic                  base_ok    = 1'b0;
	logic                  cfg_valid  = 1'b0;
	logic [LIMIT_W-1:0]    cfg_data   = '0;
	logic                  busy;
	logic                  done;
	logic                  hit;
	logic                  found;
	logic [VALUE_BITS-1:0] value_out;
	logic                  evicted;
	logic                  cfg_ready;

	int fail_count;
	int pending;
	int hit_count;
	int evict_count;
	int requests_sent = 0;
	int burst_left    = 1;
	int settings_used = 0;
	int pool_size     = 1;

	logic [KEY_BITS-1:0] key_pool [POOL_MAX];
	// 31 fills the whole cache right before 2 cuts it down, so one allocation evicts many
	logic [LIMIT_W-1:0]  limit_plan [PHASES] = '{5'd31, 5'd2, 5'd16, 5'd1, 5'd17,
		5'd4, 5'd3, 5'd8, 5'd0, 5'd6};

	always #2 clk = ~clk;

	fifo_lookaside_key_cache #(
		.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.key(key), .value(value), .base_found(base_found), .base_ok(base_ok),
		.done(done), .hit(hit), .found(found), .value_out(value_out), .evicted(evicted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	flkc_checker #(
		.DEPTH(DEPTH), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
	) scoreboard (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req_type(req_type),
		.key(key), .value(value), .base_found(base_found), .base_ok(base_ok),
		.done(done), .hit(hit), .found(found), .value_out(value_out), .evicted(evicted),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .hit_count(hit_count),
		.evict_count(evict_count)
	);

	// called at a falling edge; returns at a falling edge with start either held for the
	// next transaction of the burst or already dropped for a gap
	task automatic issue(input logic [REQ_W-1:0] rt, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v, input logic bf, input logic bok);
		int gap;
		start      <= 1'b1;
		req_type   <= rt;
		key        <= k;
		value      <= v;
		base_found <= bf;
		base_ok    <= bok;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (rt <= REQ_FLUSH)
			requests_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 14) : $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
		end
	endtask

	// stop sending and wait for every outstanding result
	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] lim);
		cfg_valid <= 1'b1;
		cfg_data  <= lim;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	function automatic logic coin();
		return 1'($urandom_range(0, 1));
	endfunction

	function automatic logic [REQ_W-1:0] pick_unknown();
		return REQ_W'($urandom_range(REQ_FLUSH + 1, (1 << REQ_W) - 1));
	endfunction

	function automatic logic [KEY_BITS-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, pool_size - 1)];
		return $urandom();
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_value();
		case ($urandom_range(0, 19))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int                  kind;
		int                  eff;
		int                  phase_start;
		int                  u;
		logic [KEY_BITS-1:0] k;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		write_limit('0);

		// directed: empty miss, fill, refill of a present key, failed and good writes
		issue(REQ_LOOKUP, '0, '1, 1'b1, 1'b1);
		issue(REQ_FILL, '0, '1, 1'b1, 1'b0);
		issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0);
		issue(REQ_FILL, '0, '0, 1'b0, 1'b1);
		issue(REQ_LOOKUP, '0, '1, 1'b1, 1'b1);
		issue(REQ_INSERT, '1, 32'ha5a5_a5a5, 1'b1, 1'b0);
		issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0);
		issue(REQ_INSERT, '1, 32'ha5a5_a5a5, 1'b0, 1'b1);
		issue(REQ_INSERT, '1, 32'h5a5a_5a5a, 1'b1, 1'b0);
		issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0);
		issue(REQ_REMOVE, '1, '1, 1'b1, 1'b1);
		issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0);
		issue(REQ_REMOVE, 32'h1234_5678, '1, 1'b0, 1'b1);
		issue(REQ_REMOVE, 32'h1234_5679, '1, 1'b1, 1'b0);
		issue(REQ_LOOKUP, 32'h1234_5678, '1, 1'b1, 1'b1);
		issue(REQ_LOOKUP, 32'h1234_5679, '1, 1'b1, 1'b1);
		issue(REQ_FILL, 32'h8000_0000, 32'h0000_0001, 1'b0, 1'b1);
		issue(REQ_LOOKUP, 32'h8000_0000, '0, 1'b0, 1'b0);
		for (u = REQ_FLUSH + 1; u < (1 << REQ_W); u++)
			issue(REQ_W'(u), '1, '1, 1'b1, 1'b1);
		issue(REQ_FLUSH, '1, '1, 1'b1, 1'b1);
		issue(REQ_LOOKUP, '0, '0, 1'b0, 1'b0);
		issue(REQ_LOOKUP, '1, '0, 1'b0, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_limit(limit_plan[p]);
			eff = (limit_plan[p] == 0 || limit_plan[p] > DEPTH) ? DEPTH : int'(limit_plan[p]);
			pool_size = eff + $urandom_range(1, 8);
			if (pool_size > POOL_MAX)
				pool_size = POOL_MAX;
			// keys one bit apart make every compare bit matter
			for (int i = 0; i < pool_size; i++) begin
				case ($urandom_range(0, 5))
					0:       key_pool[i] = '0;
					1:       key_pool[i] = '1;
					2:       key_pool[i] = (i > 0) ? key_pool[i-1] ^ (32'd1 << $urandom_range(0, 31))
						: $urandom();
					default: key_pool[i] = $urandom();
				endcase
			end
			phase_start = requests_sent;
			while (requests_sent - phase_start < ITEMS_PER_PHASE) begin
				kind = $urandom_range(0, 99);
				k    = pick_key();
				if (kind < 40) begin
					// lookup and the backing table's answer for the same key
					issue(REQ_LOOKUP, k, pick_value(), coin(), coin());
					issue(REQ_FILL, k, pick_value(), coin(), coin());
				end else if (kind < 55)
					issue(REQ_LOOKUP, k, pick_value(), coin(), coin());
				else if (kind < 70)
					issue(REQ_INSERT, k, pick_value(), coin(), $urandom_range(0, 9) != 0);
				else if (kind < 85)
					issue(REQ_REMOVE, k, pick_value(), coin(), $urandom_range(0, 6) != 0);
				else if (kind < 93)
					issue(REQ_FILL, k, pick_value(), coin(), coin());
				else if (kind < 94)
					issue(REQ_FLUSH, k, pick_value(), coin(), coin());
				else if (kind < 97)
					issue(pick_unknown(), k, pick_value(), coin(), coin());
				else begin
					issue(REQ_INSERT, k, pick_value(), coin(), 1'b1);
					issue(REQ_LOOKUP, k, pick_value(), coin(), coin());
				end
			end
		end

		settle();
		repeat (10) @(negedge clk);
		$display("covered %0d requests over %0d cache_limit settings", requests_sent, settings_used);
		$display("results: %0d hits, %0d with evictions", hit_count, evict_count);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
rtl/flkc_pkg.sv
rtl/flkc_ctrl.sv
rtl/flkc_dp.sv
rtl/fifo_lookaside_key_cache.sv
tb/flkc_checker.sv
tb/tb_fifo_lookaside_key_cache.sv
